/* design/watched_id_history_table_defines.svh */
// Assertion macros for the watched id history table.
`ifndef WATCHED_ID_HISTORY_TABLE_DEFINES_SVH
`define WATCHED_ID_HISTORY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define WHIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WHIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define WHIT_ASSERT(lbl, prop, msg)
`define WHIT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/whit_pkg.sv */
package whit_pkg;

  localparam int SlotCountDef   = 8;
  localparam int WindowDepthDef = 16;

  localparam int ChannelW = 8;
  localparam int IdW      = 16;
  localparam int TimeW    = 48;
  localparam int LenW     = 4;
  localparam int WordW    = 32;
  localparam int SeqW     = 32;
  localparam int LimitW   = 5;

  localparam int InDataW  = 152;
  localparam int OutDataW = 152;

  typedef enum logic [1:0] {
    KindWatch   = 2'd0,
    KindUnwatch = 2'd1,
    KindPush    = 2'd2,
    KindRead    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [WordW-1:0] payload_high;
    logic [WordW-1:0] payload_low;
    logic [LenW-1:0]  length_code;
    logic [TimeW-1:0] time_us;
  } entry_t;

  typedef struct packed {
    logic                set;
    logic                clr;
    logic [ChannelW-1:0] channel;
    logic [IdW-1:0]      id;
  } cam_cmd_t;

  typedef struct packed {
    logic found;
    logic free_ok;
  } cam_res_t;

  typedef struct packed {
    logic   op_ok;
    logic   was_watched;
    logic   sample_valid;
    logic   last;
    entry_t sample;
  } result_t;

endpackage

/* design/watched_id_history_table.sv */
// Channel  Dir  tdata fields (low bit up)                               tuser         tlast
// s_axis   in   channel, id, time_us, length_code, payload_low,
//               payload_high, read_limit                                 kind          -
// m_axis   out  op_ok, was_watched, out_time_us, out_length_code,
//               out_payload_low, out_payload_high, sequence_number      sample_valid  last_of_run
//
// Watch, unwatch and push are accepted with key match and slot state read, then
// update the key table, slot state and sample store in the execute state.
// A read passes StRdIssue and StRdWait for each sample, as the sample store read port is registered.
// After reset all slots are free; no clearing pass is needed.
// A full output register stalls the block until the result is taken; the next
// transaction is accepted while the last result still waits.
`include "watched_id_history_table_defines.svh"

module watched_id_history_table import whit_pkg::*; #(
  parameter int NUM_SLOTS    = SlotCountDef,
  parameter int WINDOW_DEPTH = WindowDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // channel, id, time_us, length_code, payload_low, payload_high, read_limit
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // op_ok, was_watched, out_time_us, out_length_code, out_payload_low,
  // out_payload_high, sequence_number
  output logic [OutDataW-1:0] m_axis_tdata,
  // sample_valid
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int HeadW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FillW = $clog2(WINDOW_DEPTH + 1);
  localparam int CntW  = (FillW > LimitW) ? FillW : LimitW;
  localparam int AddrW = SlotW + HeadW;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StExec    = 2'd1;
  localparam logic [1:0] StRdIssue = 2'd2;
  localparam logic [1:0] StRdWait  = 2'd3;

  typedef struct packed {
    logic [HeadW-1:0] head;
    logic [FillW-1:0] fill;
  } slot_state_t;

  logic [1:0] state_q, state_d;

  logic                accept;
  kind_e               kind_q;
  logic [ChannelW-1:0] channel_q;
  logic [IdW-1:0]      id_q;
  entry_t              frame_q;
  logic [LimitW-1:0]   limit_q;
  logic                found_q;
  logic                free_ok_q;
  logic [SlotW-1:0]    slot_q;
  logic [SlotW-1:0]    free_idx_q;

  cam_res_t         cam_res;
  logic [SlotW-1:0] cam_hit_idx;
  logic [SlotW-1:0] cam_free_idx;
  cam_cmd_t         cam_cmd;
  logic [SlotW-1:0] cam_idx;

  slot_state_t ss_mem [NUM_SLOTS];
  slot_state_t ss_rd_q;
  logic        ss_we;
  logic [SlotW-1:0] ss_waddr;
  slot_state_t ss_wdata;

  logic             st_we;
  logic [AddrW-1:0] st_waddr;
  entry_t           st_wdata;
  logic             st_re;
  logic [AddrW-1:0] st_raddr;
  entry_t           st_rdata;

  logic [SeqW-1:0]  seq_q, seq_d;
  logic [FillW-1:0] rd_left_q, rd_left_d;
  logic [HeadW-1:0] rd_idx_q, rd_idx_d;

  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t out_d;
  logic    out_load;
  logic    out_free;
  logic    exec_go;

  logic [CntW-1:0]  lim_sat;
  logic [CntW-1:0]  fill_x;
  logic [CntW-1:0]  n_cnt;
  logic [CntW:0]    head_x;
  logic [CntW:0]    n_x;
  logic [CntW:0]    start_x;
  logic [HeadW-1:0] head_inc;
  logic [HeadW-1:0] rd_idx_inc;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign exec_go       = (state_q == StExec) && out_free;

  whit_key_cam #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_cam (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .lookup_channel_i (s_axis_tdata[7:0]),
    .lookup_id_i      (s_axis_tdata[23:8]),
    .res_o            (cam_res),
    .hit_idx_o        (cam_hit_idx),
    .free_idx_o       (cam_free_idx),
    .cmd_i            (cam_cmd),
    .cmd_idx_i        (cam_idx)
  );

  whit_sample_store #(
    .NUM_SLOTS    (NUM_SLOTS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // slot head and fill memory
  always_ff @(posedge clk_i) begin
    if (ss_we) begin
      ss_mem[ss_waddr] <= ss_wdata;
    end
    if (accept) begin
      ss_rd_q <= ss_mem[cam_hit_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q               <= kind_e'(s_axis_tuser);
      channel_q            <= s_axis_tdata[7:0];
      id_q                 <= s_axis_tdata[23:8];
      frame_q.time_us      <= s_axis_tdata[71:24];
      frame_q.length_code  <= s_axis_tdata[75:72];
      frame_q.payload_low  <= s_axis_tdata[107:76];
      frame_q.payload_high <= s_axis_tdata[139:108];
      frame_q.seq          <= '0;
      limit_q              <= s_axis_tdata[144:140];
      found_q              <= cam_res.found;
      free_ok_q            <= cam_res.free_ok;
      slot_q               <= cam_hit_idx;
      free_idx_q           <= cam_free_idx;
    end
  end

  always_comb begin
    lim_sat  = (CntW'(limit_q) > CntW'(WINDOW_DEPTH)) ? CntW'(WINDOW_DEPTH) : CntW'(limit_q);
    fill_x   = found_q ? CntW'(ss_rd_q.fill) : '0;
    n_cnt    = (fill_x < lim_sat) ? fill_x : lim_sat;
    head_x   = (CntW+1)'(ss_rd_q.head);
    n_x      = (CntW+1)'(n_cnt);
    start_x  = (head_x >= n_x) ? (head_x - n_x) : (head_x + (CntW+1)'(WINDOW_DEPTH) - n_x);
    head_inc = (ss_rd_q.head == HeadW'(WINDOW_DEPTH - 1)) ? '0 : ss_rd_q.head + 1'b1;
    rd_idx_inc = (rd_idx_q == HeadW'(WINDOW_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    seq_d     = seq_q;
    rd_left_d = rd_left_q;
    rd_idx_d  = rd_idx_q;

    cam_cmd         = '0;
    cam_cmd.channel = channel_q;
    cam_cmd.id      = id_q;
    cam_idx         = slot_q;

    ss_we    = 1'b0;
    ss_waddr = slot_q;
    ss_wdata = '0;

    st_we        = 1'b0;
    st_waddr     = {slot_q, ss_rd_q.head};
    st_wdata     = frame_q;
    st_wdata.seq = seq_q;
    st_re        = 1'b0;
    st_raddr     = {slot_q, rd_idx_q};

    out_load          = 1'b0;
    out_d             = '0;
    out_d.op_ok       = found_q;
    out_d.was_watched = found_q;
    out_d.last        = 1'b1;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_go) begin
          state_d  = StIdle;
          out_load = 1'b1;
          unique case (kind_q)
            KindWatch: begin
              out_d.op_ok = found_q || free_ok_q;
              if (!found_q && free_ok_q) begin
                cam_cmd.set = 1'b1;
                cam_idx     = free_idx_q;
                ss_we       = 1'b1;
                ss_waddr    = free_idx_q;
              end
            end
            KindUnwatch: begin
              cam_cmd.clr = found_q;
            end
            KindPush: begin
              if (found_q) begin
                st_we         = 1'b1;
                ss_we         = 1'b1;
                ss_wdata.head = head_inc;
                ss_wdata.fill = (ss_rd_q.fill < FillW'(WINDOW_DEPTH)) ?
                                ss_rd_q.fill + 1'b1 : ss_rd_q.fill;
                seq_d         = seq_q + 1'b1;
              end
            end
            KindRead: begin
              if (n_cnt != '0) begin
                out_load  = 1'b0;
                state_d   = StRdIssue;
                rd_left_d = FillW'(n_cnt);
                rd_idx_d  = start_x[HeadW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      StRdIssue: begin
        st_re   = 1'b1;
        state_d = StRdWait;
      end
      StRdWait: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_d.op_ok        = 1'b1;
          out_d.was_watched  = 1'b1;
          out_d.sample_valid = 1'b1;
          out_d.sample       = st_rdata;
          out_d.last         = (rd_left_q == FillW'(1));
          rd_left_d          = rd_left_q - 1'b1;
          rd_idx_d           = rd_idx_inc;
          state_d            = (rd_left_q == FillW'(1)) ? StIdle : StRdIssue;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
      rd_left_q   <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      rd_left_q   <= rd_left_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.sample_valid;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {2'b00, out_q.sample.seq, out_q.sample.payload_high,
                          out_q.sample.payload_low, out_q.sample.length_code,
                          out_q.sample.time_us, out_q.was_watched, out_q.op_ok};

  `WHIT_ASSERT(a_seq_only_push, (!(exec_go && kind_q == KindPush && found_q)) |=> (seq_q == $past(seq_q)), "sequence moved without a push")
  `WHIT_ASSERT(a_read_count, (state_q == StRdIssue || state_q == StRdWait) |-> (rd_left_q != '0), "sample read with no samples left")
  `WHIT_ASSERT(a_fill_bound, ss_we |-> (ss_wdata.fill <= FillW'(WINDOW_DEPTH)), "fill beyond window")

endmodule

/* design/whit_key_cam.sv */
`include "watched_id_history_table_defines.svh"

module whit_key_cam import whit_pkg::*; #(
  parameter int NUM_SLOTS = SlotCountDef,
  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ChannelW-1:0] lookup_channel_i,
  input  logic [IdW-1:0]      lookup_id_i,
  output cam_res_t            res_o,
  output logic [SlotW-1:0]    hit_idx_o,
  output logic [SlotW-1:0]    free_idx_o,
  input  cam_cmd_t            cmd_i,
  input  logic [SlotW-1:0]    cmd_idx_i
);

  logic [NUM_SLOTS-1:0] in_use_q, in_use_d;
  logic [ChannelW-1:0]  channel_q [NUM_SLOTS];
  logic [IdW-1:0]       id_q      [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] hit_vec;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_vec[i] = in_use_q[i] && (channel_q[i] == lookup_channel_i) && (id_q[i] == lookup_id_i);
    end
  end

  // lowest index wins
  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx_o = SlotW'(i);
      end
      if (!in_use_q[i]) begin
        free_idx_o = SlotW'(i);
      end
    end
    res_o.found   = |hit_vec;
    res_o.free_ok = ~&in_use_q;
  end

  always_comb begin
    in_use_d = in_use_q;
    if (cmd_i.set) begin
      in_use_d[cmd_idx_i] = 1'b1;
    end else if (cmd_i.clr) begin
      in_use_d[cmd_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set) begin
      channel_q[cmd_idx_i] <= cmd_i.channel;
      id_q[cmd_idx_i]      <= cmd_i.id;
    end
  end

  `WHIT_ASSERT(a_keys_unique, $onehot0(hit_vec), "two slots hold the same key")
  `WHIT_ASSERT(a_set_free, cmd_i.set |-> !in_use_q[cmd_idx_i], "claim of a busy slot")
  `WHIT_ASSERT(a_clr_busy, cmd_i.clr |-> in_use_q[cmd_idx_i], "release of a free slot")

endmodule

/* design/whit_sample_store.sv */
module whit_sample_store import whit_pkg::*; #(
  parameter int NUM_SLOTS    = SlotCountDef,
  parameter int WINDOW_DEPTH = WindowDepthDef,
  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int HeadW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int AddrW = SlotW + HeadW,
  localparam int Depth = NUM_SLOTS * (2 ** HeadW)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/tb_watched_id_history_table.sv */
`timescale 1ns / 1ps

module tb_watched_id_history_table;
  import whit_pkg::*;

  localparam int SlotCount   = SlotCountDef;
  localparam int WindowDepth = WindowDepthDef;
  localparam int RandomItems = 234;
  localparam int CalmItems   = 40;
  localparam int PoolSize    = 16;
  localparam int CycleLimit  = 400000;

  class history_scoreboard;
    bit               in_use[SlotCount];
    logic [7:0]       chan[SlotCount];
    logic [15:0]      key_id[SlotCount];
    int unsigned      head[SlotCount];
    int unsigned      fill[SlotCount];
    entry_t           ring[SlotCount*WindowDepth];
    logic [SeqW-1:0]  seq_next;
    result_t          expected_q[$];
    int               n_in;
    int               n_out;
    int               n_samples;
    int               n_bad;

    function new();
      for (int i = 0; i < SlotCount; i++) begin
        in_use[i] = 1'b0;
        chan[i]   = '0;
        key_id[i] = '0;
        head[i]   = 0;
        fill[i]   = 0;
      end
      for (int i = 0; i < SlotCount*WindowDepth; i++) ring[i] = '0;
      seq_next  = '0;
      n_in      = 0;
      n_out     = 0;
      n_samples = 0;
      n_bad     = 0;
    endfunction

    function int find_slot(logic [7:0] ch, logic [15:0] id);
      for (int i = 0; i < SlotCount; i++)
        if (in_use[i] && chan[i] == ch && key_id[i] == id) return i;
      return -1;
    endfunction

    function void note_input(kind_e k, logic [7:0] ch, logic [15:0] id, entry_t frame,
                             logic [4:0] lim);
      int          s;
      int unsigned idx;
      int unsigned n;
      int unsigned start;
      bit          claimed;
      result_t     r;
      s = find_slot(ch, id);
      n_in++;
      r = '0;
      r.last = 1'b1;
      r.op_ok = (s >= 0);
      r.was_watched = (s >= 0);
      case (k)
        KindWatch: begin
          claimed = 1'b0;
          if (s < 0) begin
            for (int i = 0; i < SlotCount; i++) begin
              if (!claimed && !in_use[i]) begin
                in_use[i] = 1'b1;
                chan[i]   = ch;
                key_id[i] = id;
                head[i]   = 0;
                fill[i]   = 0;
                claimed   = 1'b1;
              end
            end
          end
          if (claimed) r.op_ok = 1'b1;
          expected_q.push_back(r);
        end
        KindUnwatch: begin
          if (s >= 0) begin
            in_use[s] = 1'b0;
            chan[s]   = '0;
            key_id[s] = '0;
            head[s]   = 0;
            fill[s]   = 0;
          end
          expected_q.push_back(r);
        end
        KindPush: begin
          if (s >= 0) begin
            idx = s*WindowDepth + head[s];
            ring[idx] = frame;
            ring[idx].seq = seq_next;
            seq_next = seq_next + 1'b1;
            head[s] = (head[s] + 1) % WindowDepth;
            if (fill[s] < WindowDepth) fill[s]++;
          end
          expected_q.push_back(r);
        end
        default: begin
          n = (s >= 0) ? fill[s] : 0;
          if (n > lim) n = lim;
          if (n > WindowDepth) n = WindowDepth;
          if (n == 0) begin
            expected_q.push_back(r);
          end else begin
            start = (head[s] + WindowDepth - n) % WindowDepth;
            for (int unsigned i = 0; i < n; i++) begin
              r.sample_valid = 1'b1;
              r.sample = ring[s*WindowDepth + (start + i) % WindowDepth];
              r.last = (i == n - 1);
              expected_q.push_back(r);
            end
          end
        end
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf("ok=%0d was=%0d sv=%0d last=%0d t=%h len=%h pl=%h ph=%h seq=%h",
                       r.op_ok, r.was_watched, r.sample_valid, r.last, r.sample.time_us,
                       r.sample.length_code, r.sample.payload_low, r.sample.payload_high,
                       r.sample.seq);
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      n_out++;
      if (act.sample_valid === 1'b1) n_samples++;
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result transaction: %s", show(act));
      end else begin
        exp_r = expected_q.pop_front();
        if (act !== exp_r) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch on result %0d", n_out);
            $display("  expected %s", show(exp_r));
            $display("  actual   %s", show(act));
          end
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  history_scoreboard sb;
  bit                calm;
  int                stall_left;
  int                cycle_count;

  watched_id_history_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // sink back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // accepted input transactions feed the predictor
  always @(posedge clk_i) begin
    entry_t frame;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      frame = '0;
      frame.time_us      = s_axis_tdata[71:24];
      frame.length_code  = s_axis_tdata[75:72];
      frame.payload_low  = s_axis_tdata[107:76];
      frame.payload_high = s_axis_tdata[139:108];
      sb.note_input(kind_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[23:8], frame,
                    s_axis_tdata[144:140]);
    end
  end

  always @(posedge clk_i) begin
    result_t act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = '0;
      act.op_ok               = m_axis_tdata[0];
      act.was_watched         = m_axis_tdata[1];
      act.sample.time_us      = m_axis_tdata[49:2];
      act.sample.length_code  = m_axis_tdata[53:50];
      act.sample.payload_low  = m_axis_tdata[85:54];
      act.sample.payload_high = m_axis_tdata[117:86];
      act.sample.seq          = m_axis_tdata[149:118];
      act.sample_valid        = m_axis_tuser;
      act.last                = m_axis_tlast;
      sb.check_result(act);
    end
  end

  task automatic send_txn(kind_e k, logic [7:0] ch, logic [15:0] id, logic [47:0] ts,
                          logic [3:0] len, logic [31:0] pl, logic [31:0] ph,
                          logic [4:0] lim);
    s_axis_tdata  <= {7'b0, lim, ph, pl, len, ts, id, ch};
    s_axis_tuser  <= k;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic keyed(kind_e k, logic [7:0] ch, logic [15:0] id, logic [4:0] lim);
    maybe_idle();
    send_txn(k, ch, id, 48'h0, 4'h0, 32'h0, 32'h0, lim);
  endtask

  task automatic push_frame(logic [7:0] ch, logic [15:0] id, logic [47:0] ts,
                            logic [3:0] len, logic [31:0] pl, logic [31:0] ph);
    maybe_idle();
    send_txn(KindPush, ch, id, ts, len, pl, ph, 5'd0);
  endtask

  initial begin
    logic [7:0]  pool_ch[PoolSize];
    logic [15:0] pool_id[PoolSize];
    logic [7:0]  ch;
    logic [15:0] id;
    logic [4:0]  lim;
    int          pick;
    int          roll;
    kind_e       k;

    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KindWatch;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    stall_left    = 0;
    cycle_count   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every slot, then probe the full table and unknown keys
    keyed(KindWatch, 8'd0, 16'd0, 5'd0);
    keyed(KindWatch, 8'hFF, 16'hFFFF, 5'd0);
    for (int i = 1; i <= 6; i++) keyed(KindWatch, 8'(i), 16'(i), 5'd0);
    keyed(KindWatch, 8'd7, 16'd7, 5'd0);
    keyed(KindWatch, 8'hFF, 16'hFFFF, 5'd0);
    push_frame(8'd9, 16'd9, 48'h123456789ABC, 4'h8, 32'h11223344, 32'h55667788);
    keyed(KindRead, 8'd9, 16'd9, 5'd16);
    keyed(KindUnwatch, 8'd9, 16'd9, 5'd0);
    keyed(KindRead, 8'd1, 16'd1, 5'd16);
    push_frame(8'hFF, 16'hFFFF, '1, 4'hF, '1, '1);
    push_frame(8'hFF, 16'hFFFF, '0, 4'h0, '0, '0);
    push_frame(8'd0, 16'd0, 48'hA5A5_5A5A_0F0F, 4'h5, 32'hDEADBEEF, 32'hCAFEF00D);
    keyed(KindRead, 8'hFF, 16'hFFFF, 5'd31);
    keyed(KindRead, 8'hFF, 16'hFFFF, 5'd0);
    keyed(KindRead, 8'hFF, 16'hFFFF, 5'd1);
    keyed(KindRead, 8'd0, 16'd0, 5'd16);
    keyed(KindUnwatch, 8'd0, 16'd0, 5'd0);
    keyed(KindWatch, 8'd7, 16'd7, 5'd0);
    keyed(KindRead, 8'd7, 16'd7, 5'd16);
    push_frame(8'd7, 16'd7, 48'h0000_0000_0001, 4'h1, 32'h1, 32'h2);
    keyed(KindRead, 8'd7, 16'd7, 5'd16);

    // key pool: hot keys first, then the directed keys 1 to 6, then fresh ones
    pool_ch[0] = 8'hFF; pool_id[0] = 16'hFFFF;
    pool_ch[1] = 8'd7;  pool_id[1] = 16'd7;
    for (int i = 2; i < 8; i++) begin
      pool_ch[i] = 8'(i - 1);
      pool_id[i] = 16'(i - 1);
    end
    for (int i = 8; i < PoolSize; i++) begin
      pool_ch[i] = 8'($urandom);
      pool_id[i] = 16'($urandom);
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - CalmItems) calm = 1'b1;
      if ($urandom_range(0, 1) == 0) pick = $urandom_range(0, 3);
      else pick = $urandom_range(0, PoolSize - 1);
      ch = pool_ch[pick];
      id = pool_id[pick];
      if ($urandom_range(0, 99) < 8) begin
        ch = 8'($urandom);
        id = 16'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) k = KindWatch;
      else if (roll < 22) k = KindUnwatch;
      else if (roll < 70) k = KindPush;
      else k = KindRead;
      roll = $urandom_range(0, 99);
      if (roll < 70) lim = 5'($urandom_range(0, 16));
      else if (roll < 85) lim = 5'd16;
      else lim = 5'($urandom_range(17, 31));
      maybe_idle();
      send_txn(k, ch, id, 48'({$urandom, $urandom}), 4'($urandom), $urandom, $urandom, lim);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("ran %0d input transactions, checked %0d results with %0d stored samples",
             sb.n_in, sb.n_out, sb.n_samples);
    $display("mismatches: %0d, results still expected: %0d", sb.n_bad, sb.expected_q.size());
    if (sb.n_bad == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
